// ===== design/ntc_pkg.sv =====
`timescale 1ns / 1ps
package ntc_pkg;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVF   = 2'd1;
	localparam logic [1:0] ST_UNSUP = 2'd2;

	localparam logic [1:0] SZ_1 = 2'd0;
	localparam logic [1:0] SZ_2 = 2'd1;
	localparam logic [1:0] SZ_4 = 2'd2;
	localparam logic [1:0] SZ_8 = 2'd3;

	// operation selected by the front end
	localparam logic [2:0] OP_UNSUP = 3'd0;
	localparam logic [2:0] OP_NAN   = 3'd1;
	localparam logic [2:0] OP_I2I   = 3'd2;
	localparam logic [2:0] OP_I2F   = 3'd3;
	localparam logic [2:0] OP_F2F   = 3'd4;
	localparam logic [2:0] OP_F2I   = 3'd5;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// classified item passed from front to back
	typedef struct packed {
		logic [2:0]  op;
		logic        neg;       // sign of the value
		logic [31:0] mag;       // integer magnitude (int source)
		logic [63:0] bits;      // raw float bits (float source)
		logic        src_wide;  // source is f64
		logic [1:0]  dsz;
	} cls_t;

endpackage

// ===== design/ntc_front.sv =====
`timescale 1ns / 1ps
module ntc_front import ntc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic [63:0] source_bits,
	input  logic        source_is_float,
	input  logic [1:0]  source_size,
	input  logic        dest_is_float,
	input  logic [1:0]  dest_size,
	output logic        vld_s1,
	output cls_t        cls_s1
);

	logic        s_ok, d_ok, nan;
	logic [31:0] sv;
	cls_t        c;

	always_comb begin
		s_ok = source_is_float ? (source_size >= SZ_4) : (source_size <= SZ_4);
		d_ok = dest_is_float ? (dest_size >= SZ_4) : (dest_size <= SZ_4);
		unique case (source_size)
			SZ_1:    sv = {{24{source_bits[7]}}, source_bits[7:0]};
			SZ_2:    sv = {{16{source_bits[15]}}, source_bits[15:0]};
			default: sv = source_bits[31:0];
		endcase
		nan = (source_size == SZ_4)
			? (source_bits[30:0] > 31'h7F800000)
			: (source_bits[62:0] > 63'h7FF0000000000000);
		c = '0;
		c.dsz = dest_size;
		c.bits = source_bits;
		c.src_wide = (source_size == SZ_8);
		c.neg = source_is_float ? (c.src_wide ? source_bits[63] : source_bits[31]) : sv[31];
		c.mag = sv[31] ? (32'd0 - sv) : sv;
		if (!s_ok || !d_ok)
			c.op = OP_UNSUP;
		else if (!source_is_float)
			c.op = dest_is_float ? OP_I2F : OP_I2I;
		else if (nan)
			c.op = OP_NAN;
		else
			c.op = dest_is_float ? OP_F2F : OP_F2I;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			cls_s1 <= c;
		end
	end

endmodule

// ===== design/ntc_queue.sv =====
`timescale 1ns / 1ps
module ntc_queue import ntc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  cls_t         wdata,
	input  logic         rd,
	output cls_t         rdata,
	output logic         empty,
	output logic [QAW:0] count
);

	cls_t           mem [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;

	assign empty = (count == '0);
	assign rdata = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			count <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			count <= count + (QAW+1)'(wr) - (QAW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wp_q] <= wdata;
		end
	end

endmodule

// ===== design/ntc_back.sv =====
`timescale 1ns / 1ps
module ntc_back import ntc_pkg::*; (
	input  cls_t        c,
	output logic [63:0] res,
	output logic [1:0]  st
);

	logic [4:0]  lz;
	logic [31:0] nm;
	logic        found;
	logic [7:0]  e32;
	logic [22:0] m32;
	logic        rnd;
	logic [31:0] f32;
	logic [63:0] f64;
	logic [10:0] ex;
	logic [52:0] fm;
	logic [24:0] mr;
	logic        subn;
	logic [5:0]  sh;
	logic [77:0] wm;
	logic [9:0]  ue;
	logic [31:0] t;
	logic [31:0] iv;
	logic        ovf;
	logic        iszero;

	always_comb begin
		res = '0; st = ST_OK;
		lz = '0; found = 1'b0; nm = '0; e32 = '0; m32 = '0; rnd = 1'b0;
		f32 = '0; f64 = '0; ex = '0; fm = '0; mr = '0; subn = 1'b0;
		sh = '0; wm = '0; ue = '0; t = '0; iv = '0; ovf = 1'b0; iszero = 1'b0;

		// integer magnitude to floats
		for (int i = 0; i < 32; i++)
			if (!found && c.mag[31-i]) begin found = 1'b1; lz = 5'(i); end
		nm = c.mag << lz;

		// f32 from narrowing f64 (or source f32 directly)
		if (c.src_wide) begin
			ex = c.bits[62:52];
			fm = {1'b1, c.bits[51:0]};
			iszero = (ex == '0);
			if (ex == 11'h7FF || ex > 11'd1150) begin
				f32 = {c.bits[63], 8'hFF, 23'd0};
			end else if (ex < 11'd872) begin
				f32 = {c.bits[63], 31'd0};
			end else begin
				// unbiased shift for subnormal targets
				subn = (ex < 11'd897);
				sh = subn ? 6'(11'd897 - ex) : 6'd0;
				wm = {fm, 25'd0} >> sh;
				mr = {1'b0, wm[77:54]};
				rnd = wm[53] && ((|wm[52:0]) || wm[54]);
				mr = mr + 25'(rnd);
				if (subn) begin
					f32 = {c.bits[63], 8'(mr[23]), mr[22:0]};
				end else begin
					ue = 10'(ex - 11'd896) + 10'(mr[24]);
					if (ue >= 10'd255)
						f32 = {c.bits[63], 8'hFF, 23'd0};
					else
						f32 = {c.bits[63], ue[7:0], mr[24] ? mr[23:1] : mr[22:0]};
				end
			end
			if (iszero && c.bits[51:0] == '0)
				f32 = {c.bits[63], 31'd0};
		end else begin
			f32 = c.bits[31:0];
		end

		unique case (c.op)
			OP_UNSUP: st = ST_UNSUP;
			OP_NAN:   st = ST_OVF;
			OP_I2I: begin
				iv = c.neg ? (32'd0 - c.mag) : c.mag;
				unique case (c.dsz)
					SZ_1: begin
						ovf = ($signed(iv) > 127) || ($signed(iv) < -128);
						res = {56'd0, iv[7:0]};
					end
					SZ_2: begin
						ovf = ($signed(iv) > 32767) || ($signed(iv) < -32768);
						res = {48'd0, iv[15:0]};
					end
					default: res = {32'd0, iv};
				endcase
				if (ovf) st = ST_OVF;
			end
			OP_I2F: begin
				if (c.mag == '0) begin
					res = '0;
				end else if (c.dsz == SZ_8) begin
					res = {c.neg, 11'(11'd1054 - 11'(lz)), nm[30:0], 21'd0};
				end else begin
					rnd = nm[7] && ((|nm[6:0]) || nm[8]);
					mr = {1'b0, nm[31:8]} + 25'(rnd);
					e32 = 8'(8'd158 - 8'(lz)) + 8'(mr[24]);
					m32 = mr[24] ? mr[23:1] : mr[22:0];
					res = {32'd0, c.neg, e32, m32};
				end
			end
			OP_F2F: begin
				if (!c.src_wide && c.dsz == SZ_8) begin
					// widen f32 exactly
					if (c.bits[30:23] == 8'hFF) begin
						f64 = {c.bits[31], 11'h7FF, 52'd0};
					end else if (c.bits[30:23] == '0) begin
						if (c.bits[22:0] == '0) begin
							f64 = {c.bits[31], 63'd0};
						end else begin
							found = 1'b0;
							for (int i = 0; i < 23; i++)
								if (!found && c.bits[22-i]) begin
									found = 1'b1; lz = 5'(i);
								end
							nm = {9'd0, c.bits[22:0]} << (lz + 5'd1);
							f64 = {c.bits[31], 11'(11'd896 - 11'(lz)), nm[22:0], 29'd0};
						end
					end else begin
						f64 = {c.bits[31], 11'({3'd0, c.bits[30:23]} + 11'd896),
							c.bits[22:0], 29'd0};
					end
					res = f64;
				end else if (c.src_wide && c.dsz == SZ_8) begin
					res = c.bits;
				end else begin
					res = {32'd0, f32};
				end
			end
			default: begin
				// f32 to int, truncating
				if (f32[30:23] >= 8'd158) begin
					ovf = 1'b1;
				end else if (f32[30:23] < 8'd127) begin
					t = '0;
				end else begin
					t = {1'b1, f32[22:0], 8'd0} >> 5'(8'd158 - f32[30:23]);
				end
				iv = f32[31] ? (32'd0 - t) : t;
				unique case (c.dsz)
					SZ_1: begin
						if (t > (f32[31] ? 32'd128 : 32'd127)) ovf = 1'b1;
						res = {56'd0, iv[7:0]};
					end
					SZ_2: begin
						if (t > (f32[31] ? 32'd32768 : 32'd32767)) ovf = 1'b1;
						res = {48'd0, iv[15:0]};
					end
					default: res = {32'd0, iv};
				endcase
				// -2^31 exactly is in range
				if (f32 == 32'hCF000000 && c.dsz == SZ_4) begin
					ovf = 1'b0; res = 64'h80000000;
				end
				if (ovf) st = ST_OVF;
			end
		endcase
		if (st != ST_OK) res = '0;
	end

endmodule

// ===== design/numeric_type_converter_core.sv =====
`timescale 1ns / 1ps
// Numeric type converter: int8/16/32 and f32/f64 in any supported pairing.
// Input channel: drive the fields with push high; an item is taken at a
// clock edge where full is low. Result channel: while empty is low the
// oldest result sits on result_bits/status; pop high takes it.
// A front stage registers and classifies each item; a four-entry queue
// feeds the back end, which computes the conversion combinationally from
// the queue head; empty goes low when the front register writes it to the queue.
// Throughput is one item per cycle as long as pop keeps up.
// When the receiver stalls the queue fills; full rises once the queue
// and the front register could not absorb another item.
// Reset clears the front valid and queue pointers: empty high, full low.
// Status 0 ok, 1 overflow (including NaN and 2^31), 2 unsupported pair;
// result_bits is zero whenever status is not ok.
module numeric_type_converter_core import ntc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] source_bits,
	input  logic        source_is_float,
	input  logic [1:0]  source_size,
	input  logic        dest_is_float,
	input  logic [1:0]  dest_size,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] result_bits,
	output logic [1:0]  status
);

	logic         vld_s1;
	cls_t         cls_s1;
	cls_t         head;
	logic [QAW:0] count;
	logic         rd;

	// the front slot may be in flight, so leave room for it
	assign full = (count + (QAW+1)'(vld_s1)) >= (QAW+1)'(QDEPTH);
	assign rd   = pop && !empty;

	ntc_front u_front (
		.clk, .arst_n,
		.in_vld(push && !full),
		.source_bits, .source_is_float, .source_size, .dest_is_float, .dest_size,
		.vld_s1, .cls_s1
	);

	ntc_queue u_queue (
		.clk, .arst_n,
		.wr(vld_s1), .wdata(cls_s1),
		.rd, .rdata(head), .empty, .count
	);

	ntc_back u_back (
		.c(head), .res(result_bits), .st(status)
	);

endmodule
